### src/scsc_pkg.sv
package scsc_pkg;

  // Fixed field widths of the channels.
  localparam int KIND_W   = 2;
  localparam int SLOT_W   = 6;

  // Defaults for the top-level parameters.
  localparam int ENTRIES_DEF     = 64;
  localparam int SECTOR_BITS_DEF = 32;

  // A flush reports at most this many dirty entries.
  localparam int MAX_RESULTS = 64;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  // Request codes carried by in_kind.
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd3;

  // Per-slot status bits, kept together in one memory word.
  typedef struct packed {
    logic valid;
    logic dirty;
    logic accessed;
  } flg_t;

endpackage

### src/sector_cache_second_chance.sv
// Channel   Direction  Beat contents
// in_       input      kind, sector
// out_      output     slot, hit, fill_needed, writeback_needed, writeback_sector, last
//
// Scans: an access scans the tag memory at one entry a cycle (up to ENTRIES entries, fewer
// on a hit), then, when no slot is free, the second-chance scan runs over up to ENTRIES+1
// entries, and then the result is handed over; a flush scans the entries in order, pausing at
// each dirty entry to hand over the previous report, and ends with a final beat when it
// reports any entry. Each memory has a single read port.
// Reset: a clearing pass writes every entry of the status memory; in_ready stays low.
// Stalls: out_ready low holds the result register; a flush then waits before its next beat.
module sector_cache_second_chance #(
  parameter int ENTRIES     = scsc_pkg::ENTRIES_DEF,
  parameter int SECTOR_BITS = scsc_pkg::SECTOR_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [scsc_pkg::KIND_W-1:0] in_kind,
  input  logic [SECTOR_BITS-1:0]      in_sector,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [scsc_pkg::SLOT_W-1:0] out_slot,
  output logic                        out_hit,
  output logic                        out_fill_needed,
  output logic                        out_writeback_needed,
  output logic [SECTOR_BITS-1:0]      out_writeback_sector,
  output logic                        out_last
);
  import scsc_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_LOOK, S_VICT, S_FLUSH, S_FPUT, S_LAST
  } state_t;

  // Memories: tags and status bits, registered read.
  logic [SECTOR_BITS-1:0] tag_mem [ENTRIES];
  flg_t                   flg_mem [ENTRIES];
  logic [SECTOR_BITS-1:0] tag_q;
  flg_t                   flg_q;

  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic             tag_we, flg_we;
  flg_t             flg_wdata;

  // Control registers.
  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] ev_idx_r;
  logic             free_vld_r, free_vld_nxt;
  logic             pend_vld_r, pend_vld_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Payload registers.
  logic [SECTOR_BITS-1:0] sec_r, sec_nxt;
  logic                   write_r, write_nxt;
  logic [IDX_W-1:0]       free_idx_r, free_idx_nxt;
  logic [IDX_W-1:0]       cand_idx_r, cand_idx_nxt;
  logic [SECTOR_BITS-1:0] cand_tag_r, cand_tag_nxt;
  logic [IDX_W-1:0]       res_slot_r, res_slot_nxt;
  logic                   res_hit_r, res_hit_nxt;
  logic                   res_fill_r, res_fill_nxt;
  logic                   res_wb_r, res_wb_nxt;
  logic [SECTOR_BITS-1:0] res_wbsec_r, res_wbsec_nxt;
  logic [SLOT_W-1:0]      out_slot_r;
  logic                   out_hit_r, out_fill_r, out_wb_r, out_last_r;
  logic [SECTOR_BITS-1:0] out_wbsec_r;

  logic             out_free, out_load, out_last_sel;
  logic [IDX_W-1:0] ev_next, cand_next, fill_idx;

  assign ev_next   = (ev_idx_r == LAST_IDX) ? '0 : ev_idx_r + 1'b1;
  assign cand_next = (cand_idx_r == LAST_IDX) ? '0 : cand_idx_r + 1'b1;
  assign fill_idx  = free_vld_r ? free_idx_r : ev_idx_r;
  assign out_free  = !out_valid_r || out_ready;

  assign in_ready             = (state_r == S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_slot             = out_slot_r;
  assign out_hit              = out_hit_r;
  assign out_fill_needed      = out_fill_r;
  assign out_writeback_needed = out_wb_r;
  assign out_writeback_sector = out_wbsec_r;
  assign out_last             = out_last_r;

  // Memory ports.
  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[wr_addr] <= sec_r;
    end
    tag_q <= tag_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (flg_we) begin
      flg_mem[wr_addr] <= flg_wdata;
    end
    flg_q <= flg_mem[rd_addr];
  end

  // Scans take one entry a cycle unless stalled; the entry read last cycle is evaluated.
  always_comb begin
    state_nxt     = state_r;
    free_vld_nxt  = free_vld_r;
    pend_vld_nxt  = pend_vld_r;
    cnt_nxt       = cnt_r;
    sec_nxt       = sec_r;
    write_nxt     = write_r;
    free_idx_nxt  = free_idx_r;
    cand_idx_nxt  = cand_idx_r;
    cand_tag_nxt  = cand_tag_r;
    res_slot_nxt  = res_slot_r;
    res_hit_nxt   = res_hit_r;
    res_fill_nxt  = res_fill_r;
    res_wb_nxt    = res_wb_r;
    res_wbsec_nxt = res_wbsec_r;
    rd_addr       = ev_next;
    wr_addr       = ev_idx_r;
    tag_we        = 1'b0;
    flg_we        = 1'b0;
    flg_wdata     = '0;
    out_load      = 1'b0;
    out_last_sel  = 1'b0;

    case (state_r)
      S_CLR: begin
        flg_we = 1'b1;
        if (ev_idx_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        rd_addr = '0;
        if (in_valid) begin
          sec_nxt      = in_sector;
          write_nxt    = (in_kind == KIND_WRITE);
          free_vld_nxt = 1'b0;
          pend_vld_nxt = 1'b0;
          cnt_nxt      = '0;
          case (in_kind)
            KIND_READ, KIND_WRITE: state_nxt = S_LOOK;
            KIND_FLUSH:            state_nxt = S_FLUSH;
            default:               state_nxt = S_IDLE;
          endcase
        end
      end

      // Tag lookup; remembers the lowest free slot on the way.
      S_LOOK: begin
        if (flg_q.valid && tag_q == sec_r) begin
          flg_we        = 1'b1;
          flg_wdata     = '{valid: 1'b1, dirty: flg_q.dirty | write_r, accessed: 1'b1};
          res_slot_nxt  = ev_idx_r;
          res_hit_nxt   = 1'b1;
          res_fill_nxt  = 1'b0;
          res_wb_nxt    = 1'b0;
          res_wbsec_nxt = '0;
          state_nxt     = S_LAST;
        end else begin
          if (!flg_q.valid && !free_vld_r) begin
            free_vld_nxt = 1'b1;
            free_idx_nxt = ev_idx_r;
          end
          if (ev_idx_r == LAST_IDX) begin
            if (free_vld_r || !flg_q.valid) begin
              wr_addr       = fill_idx;
              tag_we        = 1'b1;
              flg_we        = 1'b1;
              flg_wdata     = '{valid: 1'b1, dirty: write_r, accessed: 1'b1};
              res_slot_nxt  = fill_idx;
              res_hit_nxt   = 1'b0;
              res_fill_nxt  = 1'b1;
              res_wb_nxt    = 1'b0;
              res_wbsec_nxt = '0;
              state_nxt     = S_LAST;
            end else begin
              // The read address wraps to slot 0 for the victim scan.
              state_nxt = S_VICT;
            end
          end
        end
      end

      // Second chance: clear accessed bits until one is found clear.
      S_VICT: begin
        flg_we = 1'b1;
        if (flg_q.accessed) begin
          flg_wdata = '{valid: flg_q.valid, dirty: flg_q.dirty, accessed: 1'b0};
        end else begin
          tag_we        = 1'b1;
          flg_wdata     = '{valid: 1'b1, dirty: write_r, accessed: 1'b1};
          res_slot_nxt  = ev_idx_r;
          res_hit_nxt   = 1'b0;
          res_fill_nxt  = 1'b1;
          res_wb_nxt    = flg_q.dirty;
          res_wbsec_nxt = flg_q.dirty ? tag_q : '0;
          state_nxt     = S_LAST;
        end
      end

      // Flush scan stops at each dirty entry so the previous one can go out.
      S_FLUSH: begin
        if (flg_q.valid && flg_q.dirty) begin
          cand_idx_nxt = ev_idx_r;
          cand_tag_nxt = tag_q;
          state_nxt    = S_FPUT;
        end else if (ev_idx_r == LAST_IDX) begin
          state_nxt = pend_vld_r ? S_LAST : S_IDLE;
        end
      end

      S_FPUT: begin
        rd_addr = cand_next;
        if (!pend_vld_r || out_free) begin
          out_load      = pend_vld_r;
          res_slot_nxt  = cand_idx_r;
          res_hit_nxt   = 1'b0;
          res_fill_nxt  = 1'b0;
          res_wb_nxt    = 1'b1;
          res_wbsec_nxt = cand_tag_r;
          pend_vld_nxt  = 1'b1;
          cnt_nxt       = cnt_r + 1'b1;
          if (cnt_r == CNT_W'(MAX_RESULTS - 1) || cand_idx_r == LAST_IDX) begin
            state_nxt = S_LAST;
          end else begin
            state_nxt = S_FLUSH;
          end
        end
      end

      S_LAST: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_last_sel = 1'b1;
          pend_vld_nxt = 1'b0;
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = out_load || (out_valid_r && !out_ready);
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      ev_idx_r    <= '0;
      free_vld_r  <= 1'b0;
      pend_vld_r  <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ev_idx_r    <= rd_addr;
      free_vld_r  <= free_vld_nxt;
      pend_vld_r  <= pend_vld_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and the result register.
  always_ff @(posedge clk) begin
    sec_r       <= sec_nxt;
    write_r     <= write_nxt;
    free_idx_r  <= free_idx_nxt;
    cand_idx_r  <= cand_idx_nxt;
    cand_tag_r  <= cand_tag_nxt;
    res_slot_r  <= res_slot_nxt;
    res_hit_r   <= res_hit_nxt;
    res_fill_r  <= res_fill_nxt;
    res_wb_r    <= res_wb_nxt;
    res_wbsec_r <= res_wbsec_nxt;
    if (out_load) begin
      out_slot_r  <= SLOT_W'(res_slot_r);
      out_hit_r   <= res_hit_r;
      out_fill_r  <= res_fill_r;
      out_wb_r    <= res_wb_r;
      out_wbsec_r <= res_wbsec_r;
      out_last_r  <= out_last_sel;
    end
  end

  // A hit never asks for a fill or a writeback.
  a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_hit_r |-> !out_fill_r && !out_wb_r)
    else $error("hit beat carries fill or writeback");

  // Only a flush sends beats before its last one; each such earlier beat is a flush report.
  a_flush_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |-> out_wb_r && !out_fill_r && !out_hit_r)
    else $error("non-final beat is not a flush report");

  // No item is taken during the clearing pass.
  a_no_take_clr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLR |-> !in_ready)
    else $error("input ready during clearing pass");

  // Memories are written only while an item or the clearing pass is in progress.
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE || state_r == S_LAST || state_r == S_FLUSH |-> !flg_we && !tag_we)
    else $error("memory write outside update states");

  // A pending flush report never survives the return to idle.
  a_pend_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LAST && out_free |=> !pend_vld_r)
    else $error("pending report left after last beat");

endmodule

### tb/scsc_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the sector cache, keeps its own copy of the tag and
// status arrays, and compares every result beat with the oldest expected one.
module scsc_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [scsc_pkg::KIND_W-1:0] in_kind,
  input  logic [31:0]                 in_sector,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [scsc_pkg::SLOT_W-1:0] out_slot,
  input  logic                        out_hit,
  input  logic                        out_fill_needed,
  input  logic                        out_writeback_needed,
  input  logic [31:0]                 out_writeback_sector,
  input  logic                        out_last,
  output int                          errors,
  output int                          outstanding
);
  import scsc_pkg::*;

  localparam int NSLOT = ENTRIES_DEF;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              hit;
    logic              fill;
    logic              wb;
    logic [31:0]       wb_sector;
    logic              last;
  } cache_result_t;

  // Shadow copy of the cache directory.
  logic        slot_valid    [NSLOT];
  logic [31:0] slot_tag      [NSLOT];
  logic        slot_dirty    [NSLOT];
  logic        slot_accessed [NSLOT];

  cache_result_t pending_results[$];
  int mismatches = 0;

  assign errors = mismatches;

  // Second chance: clear accessed bits from slot 0 until one is already clear.
  function automatic int second_chance_victim();
    for (int pass = 0; pass < 2; pass++) begin
      for (int i = 0; i < NSLOT; i++) begin
        if (!slot_accessed[i]) return i;
        slot_accessed[i] = 1'b0;
      end
    end
    return 0;
  endfunction

  // Read or write: lookup, then free slot or eviction, then one result.
  function automatic void predict_access(input logic [KIND_W-1:0] kind,
                                         input logic [31:0] sector);
    int            idx;
    logic          found;
    logic          wb;
    logic [31:0]   wbs;
    cache_result_t r;
    idx   = -1;
    found = 1'b0;
    wb    = 1'b0;
    wbs   = '0;
    for (int i = 0; i < NSLOT; i++) begin
      if (!found && slot_valid[i] && slot_tag[i] == sector) begin
        idx   = i;
        found = 1'b1;
      end
    end
    if (!found) begin
      for (int i = 0; i < NSLOT; i++) begin
        if (idx < 0 && !slot_valid[i]) idx = i;
      end
      if (idx < 0) begin
        idx = second_chance_victim();
        if (slot_dirty[idx]) begin
          wb  = 1'b1;
          wbs = slot_tag[idx];
        end
      end
      slot_valid[idx] = 1'b1;
      slot_tag[idx]   = sector;
      slot_dirty[idx] = 1'b0;
    end
    slot_accessed[idx] = 1'b1;
    if (kind == KIND_WRITE) slot_dirty[idx] = 1'b1;
    r.slot      = SLOT_W'(idx);
    r.hit       = found;
    r.fill      = !found;
    r.wb        = wb;
    r.wb_sector = wbs;
    r.last      = 1'b1;
    pending_results.push_back(r);
  endfunction

  // Flush: one result per valid dirty slot in slot order, capped, dirty bits kept.
  function automatic void predict_flush();
    int            total;
    int            n;
    cache_result_t r;
    total = 0;
    n     = 0;
    for (int i = 0; i < NSLOT; i++) begin
      if (slot_valid[i] && slot_dirty[i] && total < MAX_RESULTS) total++;
    end
    for (int i = 0; i < NSLOT; i++) begin
      if (slot_valid[i] && slot_dirty[i] && n < MAX_RESULTS) begin
        n++;
        r.slot      = SLOT_W'(i);
        r.hit       = 1'b0;
        r.fill      = 1'b0;
        r.wb        = 1'b1;
        r.wb_sector = slot_tag[i];
        r.last      = (n == total);
        pending_results.push_back(r);
      end
    end
  endfunction

  // Result beats are checked before the input beat of the same edge is predicted.
  always @(posedge clk) begin
    cache_result_t got;
    cache_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < NSLOT; i++) begin
        slot_valid[i]    = 1'b0;
        slot_tag[i]      = '0;
        slot_dirty[i]    = 1'b0;
        slot_accessed[i] = 1'b0;
      end
      pending_results.delete();
      outstanding <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_slot, out_hit, out_fill_needed, out_writeback_needed,
                out_writeback_sector, out_last};
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result slot=%0d hit=%0b fill=%0b wb=%0b wbsec=%0h last=%0b",
                     $realtime, got.slot, got.hit, got.fill, got.wb, got.wb_sector, got.last);
        end else begin
          want = pending_results.pop_front();
          if (got.slot !== want.slot || got.hit !== want.hit || got.fill !== want.fill ||
              got.wb !== want.wb || got.wb_sector !== want.wb_sector ||
              got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected slot=%0d hit=%0b fill=%0b wb=%0b wbsec=%0h last=%0b",
                       want.slot, want.hit, want.fill, want.wb, want.wb_sector, want.last);
              $display("  actual   slot=%0d hit=%0b fill=%0b wb=%0b wbsec=%0h last=%0b",
                       got.slot, got.hit, got.fill, got.wb, got.wb_sector, got.last);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_kind == KIND_FLUSH) begin
          predict_flush();
        end else if (in_kind == KIND_READ || in_kind == KIND_WRITE) begin
          predict_access(in_kind, in_sector);
        end
      end
      outstanding <= pending_results.size();
    end
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import scsc_pkg::*;

  localparam int POOL_SIZE  = 80;
  localparam int PHASE_LEN  = 60;
  localparam int RAND_ITEMS = 80;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  logic [KIND_W-1:0] in_kind   = KIND_READ;
  logic [31:0]       in_sector = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [SLOT_W-1:0] out_slot;
  logic              out_hit;
  logic              out_fill_needed;
  logic              out_writeback_needed;
  logic [31:0]       out_writeback_sector;
  logic              out_last;

  int errors;
  int outstanding;
  int send_idle_pct = 35;
  int recv_idle_pct = 47;
  int beats_sent    = 0;

  logic [31:0] sector_pool [POOL_SIZE];

  sector_cache_second_chance DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_kind              (in_kind),
    .in_sector            (in_sector),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_slot             (out_slot),
    .out_hit              (out_hit),
    .out_fill_needed      (out_fill_needed),
    .out_writeback_needed (out_writeback_needed),
    .out_writeback_sector (out_writeback_sector),
    .out_last             (out_last)
  );

  scsc_checker u_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_kind              (in_kind),
    .in_sector            (in_sector),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_slot             (out_slot),
    .out_hit              (out_hit),
    .out_fill_needed      (out_fill_needed),
    .out_writeback_needed (out_writeback_needed),
    .out_writeback_sector (out_writeback_sector),
    .out_last             (out_last),
    .errors               (errors),
    .outstanding          (outstanding)
  );

  always #2 clk = ~clk;

  // The receiver stalls at random with the current idle rate.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Drives one input beat and returns at the edge where it is accepted.
  // The idle rates swap after the first phase and drop to zero after the second.
  task automatic send_beat(input logic [KIND_W-1:0] kind, input logic [31:0] sector);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_kind   <= kind;
    in_sector <= sector;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
    if (beats_sent == PHASE_LEN) begin
      send_idle_pct = 47;
      recv_idle_pct = 35;
    end else if (beats_sent == 2 * PHASE_LEN) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  // Holds the sender off until every expected result has arrived.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    int pick;
    for (int i = 0; i < POOL_SIZE; i++) sector_pool[i] = $urandom();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty flush, extreme sectors, hits on reads and writes,
    // flushes with dirty entries, and the unused kind.
    send_beat(KIND_FLUSH, 32'hFFFF_FFFF);
    send_beat(KIND_READ,  32'h0000_0000);
    send_beat(KIND_WRITE, 32'hFFFF_FFFF);
    send_beat(KIND_READ,  32'hFFFF_FFFF);
    send_beat(KIND_WRITE, 32'h0000_0000);
    send_beat(KIND_FLUSH, 32'h0000_0000);
    send_beat(KIND_NONE,  32'h1234_5678);
    send_beat(KIND_READ,  32'h8000_0000);
    send_beat(KIND_WRITE, 32'h7FFF_FFFF);
    send_beat(KIND_NONE,  32'hFFFF_FFFF);
    send_beat(KIND_READ,  32'h7FFF_FFFF);
    send_beat(KIND_WRITE, 32'h0000_0001);
    send_beat(KIND_READ,  32'hFFFF_FFFE);
    send_beat(KIND_FLUSH, 32'hFFFF_FFFF);
    drain_results();

    // Write 64 fresh sectors: fills every slot, then evicts with all accessed
    // bits set, then a flush that reports the full set of dirty slots.
    for (int i = 0; i < ENTRIES_DEF; i++) send_beat(KIND_WRITE, sector_pool[i]);
    send_beat(KIND_FLUSH, $urandom());
    drain_results();

    // Random traffic over a working set larger than the cache.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      pick = $urandom_range(99);
      if (pick < 40)
        send_beat(KIND_READ, sector_pool[$urandom_range(POOL_SIZE - 1)]);
      else if (pick < 75)
        send_beat(KIND_WRITE, sector_pool[$urandom_range(POOL_SIZE - 1)]);
      else if (pick < 83)
        send_beat(KIND_FLUSH, $urandom());
      else if (pick < 88)
        send_beat(KIND_NONE, $urandom());
      else if (pick < 94)
        send_beat(KIND_READ, $urandom());
      else
        send_beat(KIND_WRITE, $urandom());
    end

    // Wait out the last results and the longest access time.
    drain_results();
    repeat (400) @(posedge clk);

    if (errors == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog on the whole run.
  initial begin
    #3_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

### sector_cache_second_chance.f
src/scsc_pkg.sv
src/sector_cache_second_chance.sv
tb/scsc_checker.sv
tb/tb_top.sv
